// ----- design/pidr_pkg.sv -----
package pidr_pkg;

   localparam int DATA_W    = 16;
   localparam int ERR_W     = 17;
   localparam int DERR_W    = 18;
   localparam int GAIN_W    = 32;
   localparam int TICK_W    = 32;
   localparam int INTEG_W   = 48;
   localparam int WIDE_W    = 64;
   localparam int CSR_W     = 33;
   localparam int CSR_IDX_W = 3;
   localparam int ACTION_W  = 3;

   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W = 48;
   localparam int DIV_D_W = 32;

   localparam logic [CSR_W-1:0] MODE_RESET = 33'd20;

   localparam logic [WIDE_W-1:0]        SATQ     = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic signed [WIDE_W-1:0] SATQ_S   = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [WIDE_W-1:0] PRESAT_S = 64'sh0000_0100_0000_0000;

   localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_SAMPLE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REPEAT = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RESET  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_SKIP   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_KP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KF    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OLIM  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ISLIM = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 3'd7;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic signed [DATA_W-1:0] actual;
      logic signed [DATA_W-1:0] setpoint;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive;
      logic                     updated;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_MUL, ST_MWAIT, ST_DIV, ST_DWAIT,
      ST_SUM, ST_RAMP, ST_LIMIT, ST_ROUND, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_FF, OP_P, OP_D, OP_E, OP_I, OP_UP, OP_DN, OP_FM, OP_FL
   } op_type;

   function automatic logic [WIDE_W-1:0] sat_mag(input logic [MUL_P_W-1:0] m);
      if (m > MUL_P_W'(SATQ)) begin
         return SATQ;
      end else begin
         return m[WIDE_W-1:0];
      end
   endfunction

   function automatic logic signed [WIDE_W-1:0] with_sign(input logic neg,
                                                          input logic [WIDE_W-1:0] mag);
      logic signed [WIDE_W-1:0] s;
      s = $signed(mag);
      return neg ? -s : s;
   endfunction

   function automatic logic signed [WIDE_W-1:0] clip64(input logic signed [WIDE_W-1:0] v,
                                                       input logic signed [WIDE_W-1:0] lo,
                                                       input logic signed [WIDE_W-1:0] hi);
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end else begin
         return v;
      end
   endfunction

   function automatic logic between(input logic signed [WIDE_W-1:0] v,
                                    input logic signed [WIDE_W-1:0] lo,
                                    input logic signed [WIDE_W-1:0] hi);
      return (lo < v) && (v < hi);
   endfunction

endpackage

// ----- design/pidr_mul.sv -----
module pidr_mul #(
   parameter int A_W = pidr_pkg::MUL_A_W,
   parameter int B_W = pidr_pkg::MUL_B_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [A_W-1:0]   mul_a,
   input  logic [B_W-1:0]   mul_b,
   output logic             done,
   output logic [A_W+B_W-1:0] product
);
   localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

   logic [A_W+B_W-1:0] acc_ff, acc_in;
   logic [A_W-1:0]     mcand_ff, mcand_in;
   logic [B_W-1:0]     mplier_ff, mplier_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [A_W:0]       hi_sum;

   // one multiplier bit per cycle, accumulator shifts right
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      hi_sum    = {1'b0, acc_ff[A_W+B_W-1:B_W]} + (mplier_ff[0] ? {1'b0, mcand_ff} : '0);
      if (start) begin
         acc_in    = '0;
         mcand_in  = mul_a;
         mplier_in = mul_b;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = {hi_sum, acc_ff[B_W-1:1]};
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- design/pidr_div.sv -----
module pidr_div #(
   parameter int N_W = pidr_pkg::DIV_N_W,
   parameter int D_W = pidr_pkg::DIV_D_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           done,
   output logic [N_W-1:0] quotient
);
   localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

   logic [D_W-1:0]   rem_ff, rem_in;
   logic [N_W-1:0]   quot_ff, quot_in;
   logic [D_W-1:0]   dvsr_ff, dvsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D_W:0]     rem_sh, diff;
   logic             ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, quot_ff[N_W-1]};
      diff    = rem_sh - {1'b0, dvsr_ff};
      ge      = rem_sh >= {1'b0, dvsr_ff};
      if (start) begin
         rem_in  = '0;
         quot_in = dividend;
         dvsr_in = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
         quot_in = {quot_ff[N_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvsr_ff <= dvsr_in;
      cnt_ff  <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ----- design/pid_controller_with_ramp_limits.sv -----
// Tick, reset, skip and unused items go from ST_IDLE straight to ST_DONE;
// arming and held samples pass ST_CHECK first. ST_DONE waits while a result stalls.
// A computing sample runs five to nine products on the 32-step shift-add multiplier
// and one quotient on the 48-step divider.
// One item at a time; the next item is taken once the result is loaded.
// Reset (synchronous, active high) clears loop state, arms the first sample and
// returns all control registers to their defaults.
module pid_controller_with_ramp_limits (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pidr_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pidr_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [pidr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pidr_pkg::CSR_W-1:0]          csr_wdata
);
   import pidr_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [GAIN_W-1:0] kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in, kf_ff, kf_in;
   logic [GAIN_W-1:0] olim_ff, olim_in, islim_ff, islim_in, ramp_ff, ramp_in;
   logic [CSR_W-1:0]  mode_ff, mode_in;

   logic [TICK_W-1:0]         tick_ff, tick_in, last_time_ff, last_time_in;
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [DATA_W-1:0]  last_drive_ff, last_drive_in;
   logic signed [DATA_W-1:0]  held_act_ff, held_act_in, held_sp_ff, held_sp_in;
   logic                      first_ff, first_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic signed [DATA_W-1:0]  act_ff, act_in, sp_ff, sp_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic [TICK_W-1:0]         elapsed_ff, elapsed_in;
   logic signed [DERR_W-1:0]  spf_ff, spf_in;
   logic signed [WIDE_W-1:0]  f_ff, f_in, p_ff, p_in, d_ff, d_in, i_ff, i_in;
   logic signed [WIDE_W-1:0]  out_ff, out_in, up_ff, up_in, dn_ff, dn_in;
   logic [DIV_N_W-1:0]        dmag_ff, dmag_in;
   logic                      dneg_ff, dneg_in;
   logic signed [INTEG_W-1:0] sum_ff, sum_in;
   logic                      viol_ff, viol_in;
   logic                      upd_ff, upd_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      rev;
   logic [DATA_W-1:0]         strength, period_c, range_c;
   logic signed [ERR_W-1:0]   err_c;
   logic [TICK_W-1:0]         elapsed_c;
   logic signed [DERR_W-1:0]  rng_s, sp18, lo18, hi18, spf_c, derr_c;

   logic signed [WIDE_W-1:0]  mul_src;
   logic [WIDE_W-1:0]         src_mag;
   logic                      mul_neg;
   logic [MUL_B_W-1:0]        mul_b;
   logic                      mul_start, mul_done;
   logic [MUL_P_W-1:0]        mul_product;
   logic                      div_start, div_done;
   logic [DIV_N_W-1:0]        div_quot;

   logic signed [WIDE_W-1:0]  prod_sat_s, prod_raw_s, sum_wide;
   logic signed [WIDE_W-1:0]  fr, pr, dr, ir, ilim, ic, total;
   logic signed [WIDE_W-1:0]  lastq, ramp_lo, ramp_hi, mn, mx, lim_out, rnd;

   assign rev      = mode_ff[32];
   assign strength = mode_ff[31:16];
   assign period_c = (mode_ff[15:0] == '0) ? 16'd1 : mode_ff[15:0];
   assign range_c  = islim_ff[15:0];

   assign err_c     = ERR_W'(sp_ff) - ERR_W'(act_ff);
   assign elapsed_c = tick_ff - last_time_ff;
   assign rng_s     = $signed({2'b00, range_c});
   assign sp18      = DERR_W'(sp_ff);
   assign lo18      = DERR_W'(act_ff) - rng_s;
   assign hi18      = DERR_W'(act_ff) + rng_s;
   assign spf_c     = (range_c == '0) ? sp18 :
                      (sp18 > hi18) ? hi18 : (sp18 < lo18) ? lo18 : sp18;
   assign derr_c    = DERR_W'(err_ff) - DERR_W'(prev_err_ff);

   // operand select for the shared multiplier
   always_comb begin
      mul_src = '0;
      mul_b   = '0;
      case (op_ff)
         OP_FF: begin
            mul_src = WIDE_W'(spf_ff);
            mul_b   = kf_ff;
         end
         OP_P: begin
            mul_src = WIDE_W'(err_ff);
            mul_b   = kp_ff;
         end
         OP_D: begin
            mul_src = WIDE_W'(derr_c);
            mul_b   = kd_ff;
         end
         OP_E: begin
            mul_src = WIDE_W'(err_ff);
            mul_b   = elapsed_ff;
         end
         OP_I: begin
            mul_src = WIDE_W'(sum_ff);
            mul_b   = ki_ff;
         end
         OP_UP: begin
            mul_src = $signed(WIDE_W'(ramp_ff[31:16]));
            mul_b   = elapsed_ff;
         end
         OP_DN: begin
            mul_src = WIDE_W'($signed(ramp_ff[15:0]));
            mul_b   = elapsed_ff;
         end
         OP_FM: begin
            mul_src = out_ff;
            mul_b   = MUL_B_W'(17'h10000 - 17'(strength));
         end
         OP_FL: begin
            mul_src = WIDE_W'(last_drive_ff);
            mul_b   = MUL_B_W'(strength);
         end
         default: begin
            mul_src = '0;
            mul_b   = '0;
         end
      endcase
   end

   assign mul_neg = mul_src < 0;
   assign src_mag = mul_neg ? WIDE_W'(-mul_src) : WIDE_W'(mul_src);

   pidr_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_a   (src_mag[MUL_A_W-1:0]),
      .mul_b   (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   pidr_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dmag_ff),
      .divisor  (elapsed_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign prod_sat_s = with_sign(mul_neg, sat_mag(mul_product));
   assign prod_raw_s = with_sign(mul_neg, mul_product[WIDE_W-1:0]);
   assign sum_wide   = WIDE_W'(integ_ff) + prod_raw_s;

   assign fr    = rev ? -f_ff : f_ff;
   assign pr    = rev ? -p_ff : p_ff;
   assign dr    = rev ? -d_ff : d_ff;
   assign ir    = rev ? -i_ff : i_ff;
   assign ilim  = $signed({32'h0, islim_ff[31:16], 16'h0});
   assign ic    = (ilim != 0) ? clip64(ir, -ilim, ilim) : ir;
   assign total = fr + pr + dr + ic;

   assign lastq   = $signed({{32{last_drive_ff[15]}}, last_drive_ff, 16'h0});
   assign ramp_lo = (last_drive_ff > 16'sd0) ? lastq + dn_ff : lastq - up_ff;
   assign ramp_hi = (last_drive_ff > 16'sd0) ? lastq + up_ff : lastq - dn_ff;
   assign mn      = $signed({{32{olim_ff[31]}}, olim_ff[31:16], 16'h0});
   assign mx      = $signed({{32{olim_ff[15]}}, olim_ff[15:0], 16'h0});
   assign lim_out = (mn != mx) ? clip64(out_ff, mn, mx) : out_ff;
   assign rnd     = (out_ff + 64'sd32768) >>> 16;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      kp_in         = kp_ff;
      ki_in         = ki_ff;
      kd_in         = kd_ff;
      kf_in         = kf_ff;
      olim_in       = olim_ff;
      islim_in      = islim_ff;
      ramp_in       = ramp_ff;
      mode_in       = mode_ff;
      tick_in       = tick_ff;
      last_time_in  = last_time_ff;
      prev_err_in   = prev_err_ff;
      integ_in      = integ_ff;
      last_drive_in = last_drive_ff;
      held_act_in   = held_act_ff;
      held_sp_in    = held_sp_ff;
      first_in      = first_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      act_in        = act_ff;
      sp_in         = sp_ff;
      err_in        = err_ff;
      elapsed_in    = elapsed_ff;
      spf_in        = spf_ff;
      f_in          = f_ff;
      p_in          = p_ff;
      d_in          = d_ff;
      i_in          = i_ff;
      out_in        = out_ff;
      up_in         = up_ff;
      dn_in         = dn_ff;
      dmag_in       = dmag_ff;
      dneg_in       = dneg_ff;
      sum_in        = sum_ff;
      viol_in       = viol_ff;
      upd_in        = upd_ff;
      rsp_in        = rsp_ff;
      req_ready     = 1'b0;
      mul_start     = 1'b0;
      div_start     = 1'b0;

      if (csr_write) begin
         case (csr_index)
            CSR_KP:    kp_in    = csr_wdata[GAIN_W-1:0];
            CSR_KI:    ki_in    = csr_wdata[GAIN_W-1:0];
            CSR_KD:    kd_in    = csr_wdata[GAIN_W-1:0];
            CSR_KF:    kf_in    = csr_wdata[GAIN_W-1:0];
            CSR_OLIM:  olim_in  = csr_wdata[GAIN_W-1:0];
            CSR_ISLIM: islim_in = csr_wdata[GAIN_W-1:0];
            CSR_RAMP:  ramp_in  = csr_wdata[GAIN_W-1:0];
            CSR_MODE:  mode_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               upd_in   = 1'b0;
               state_in = ST_DONE;
               case (req_data.action)
                  ACT_TICK: tick_in = tick_ff + 1'b1;
                  ACT_SAMPLE: begin
                     held_sp_in  = req_data.setpoint;
                     held_act_in = req_data.actual;
                     act_in      = req_data.actual;
                     sp_in       = req_data.setpoint;
                     state_in    = ST_CHECK;
                  end
                  ACT_REPEAT: begin
                     act_in   = held_act_ff;
                     sp_in    = held_sp_ff;
                     state_in = ST_CHECK;
                  end
                  ACT_RESET: begin
                     first_in = 1'b1;
                     integ_in = '0;
                  end
                  ACT_SKIP: last_time_in = tick_ff;
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            state_in = ST_DONE;
            if (first_ff) begin
               prev_err_in   = err_c;
               last_drive_in = '0;
               last_time_in  = tick_ff;
               first_in      = 1'b0;
            end else if (elapsed_c >= TICK_W'(period_c)) begin
               err_in     = err_c;
               elapsed_in = elapsed_c;
               spf_in     = spf_c;
               viol_in    = 1'b0;
               op_in      = OP_FF;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_start = 1'b1;
            state_in  = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (mul_done) begin
               state_in = ST_MUL;
               case (op_ff)
                  OP_FF: begin
                     f_in  = prod_sat_s;
                     op_in = OP_P;
                  end
                  OP_P: begin
                     p_in  = prod_sat_s;
                     op_in = OP_D;
                  end
                  OP_D: begin
                     dmag_in  = DIV_N_W'(sat_mag(mul_product));
                     dneg_in  = mul_neg;
                     state_in = ST_DIV;
                  end
                  OP_E: begin
                     sum_in = INTEG_W'(clip64(sum_wide, -SATQ_S, SATQ_S));
                     op_in  = OP_I;
                  end
                  OP_I: begin
                     i_in     = prod_sat_s;
                     state_in = ST_SUM;
                  end
                  OP_UP: begin
                     up_in = $signed({mul_product[55:0], 8'h0});
                     op_in = OP_DN;
                  end
                  OP_DN: begin
                     dn_in    = with_sign(mul_neg, {mul_product[55:0], 8'h0});
                     state_in = ST_RAMP;
                  end
                  OP_FM: begin
                     out_in = prod_raw_s >>> 16;
                     op_in  = OP_FL;
                  end
                  OP_FL: begin
                     out_in   = out_ff + prod_raw_s;
                     state_in = ST_ROUND;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_done) begin
               d_in     = with_sign(dneg_ff, WIDE_W'(div_quot));
               op_in    = OP_E;
               state_in = ST_MUL;
            end
         end
         ST_SUM: begin
            out_in = total;
            if (ilim != 0 && !between(ir, -ilim, ilim)) begin
               viol_in = 1'b1;
            end
            if (ramp_ff[31:16] != '0 && ramp_ff[15:0] != '0) begin
               op_in    = OP_UP;
               state_in = ST_MUL;
            end else begin
               state_in = ST_LIMIT;
            end
         end
         ST_RAMP: begin
            if (!between(out_ff, ramp_lo, ramp_hi)) begin
               out_in  = clip64(out_ff, ramp_lo, ramp_hi);
               viol_in = 1'b1;
            end
            state_in = ST_LIMIT;
         end
         ST_LIMIT: begin
            if (mn != mx && !between(out_ff, mn, mx)) begin
               viol_in = 1'b1;
            end
            out_in = clip64(lim_out, -PRESAT_S, PRESAT_S);
            if (strength != '0) begin
               op_in    = OP_FM;
               state_in = ST_MUL;
            end else begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            last_drive_in = DATA_W'(clip64(rnd, -64'sd32768, 64'sd32767));
            last_time_in  = tick_ff;
            prev_err_in   = err_ff;
            integ_in      = viol_ff ? integ_ff : sum_ff;
            upd_in        = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.drive   = last_drive_ff;
               rsp_in.updated = upd_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         kp_ff         <= '0;
         ki_ff         <= '0;
         kd_ff         <= '0;
         kf_ff         <= '0;
         olim_ff       <= '0;
         islim_ff      <= '0;
         ramp_ff       <= '0;
         mode_ff       <= MODE_RESET;
         tick_ff       <= '0;
         last_time_ff  <= '0;
         prev_err_ff   <= '0;
         integ_ff      <= '0;
         last_drive_ff <= '0;
         held_act_ff   <= '0;
         held_sp_ff    <= '0;
         first_ff      <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         kp_ff         <= kp_in;
         ki_ff         <= ki_in;
         kd_ff         <= kd_in;
         kf_ff         <= kf_in;
         olim_ff       <= olim_in;
         islim_ff      <= islim_in;
         ramp_ff       <= ramp_in;
         mode_ff       <= mode_in;
         tick_ff       <= tick_in;
         last_time_ff  <= last_time_in;
         prev_err_ff   <= prev_err_in;
         integ_ff      <= integ_in;
         last_drive_ff <= last_drive_in;
         held_act_ff   <= held_act_in;
         held_sp_ff    <= held_sp_in;
         first_ff      <= first_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      act_ff     <= act_in;
      sp_ff      <= sp_in;
      err_ff     <= err_in;
      elapsed_ff <= elapsed_in;
      spf_ff     <= spf_in;
      f_ff       <= f_in;
      p_ff       <= p_in;
      d_ff       <= d_in;
      i_ff       <= i_in;
      out_ff     <= out_in;
      up_ff      <= up_in;
      dn_ff      <= dn_in;
      dmag_ff    <= dmag_in;
      dneg_ff    <= dneg_in;
      sum_ff     <= sum_in;
      viol_ff    <= viol_in;
      upd_ff     <= upd_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/pidr_chk.sv -----
module pidr_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pidr_pkg::rsp_type rsp_data
);

   // one item in flight: no new item the cycle after one is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while previous item still in work");

   // a new result only appears after a busy cycle
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without an item in work");

   // the block is ready for a new item as soon as its result appears
   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("block not ready after loading result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind pid_controller_with_ramp_limits pidr_chk u_pidr_chk (.*);

// ----- tb/pid_controller_with_ramp_limits_test.sv -----
module pid_controller_with_ramp_limits_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pidr_pkg::*;

   localparam longint SAT_MAG = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint PRE_MAG = 64'sh0000_0100_0000_0000;
   localparam logic [ACTION_W-1:0] ACT_SPARE = 3'd7;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   rsp_type       rsp_data;
   logic          csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   pid_controller_with_ramp_limits dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // controller model
   bit [CSR_W-1:0] regs [8];
   bit [31:0] tick_now, last_time;
   int        prev_err, last_drive, held_actual, held_setpoint;
   longint    err_sum;
   bit        arm_pending;

   rsp_type   drive_expect[$];
   int        fail_count = 0;
   bit        calm;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      #50ms;
      $display("pid_controller_with_ramp_limits_test: FAIL");
      $finish;
   end

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      fail_count++;
   endtask

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic longint gain_prod(longint v, bit [31:0] g);
      longint unsigned m, p, gu;
      m = (v < 0) ? longint'(-v) : v;
      gu = {32'd0, g};
      if (gu != 0 && m > longint'(SAT_MAG) / gu) p = SAT_MAG;
      else p = m * gu;
      return (v < 0) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint floor_q16(longint x);
      if (x >= 0) return x / 65536;
      return -((-x + 65535) / 65536);
   endfunction

   function automatic bit pid_predict(longint act, longint sp);
      bit       rev;
      longint   strength, period, el, r, spf, f, p, i, d, outv, lastq, ilim;
      longint   rise, desc, up, dn, lo, hi, mn, mx, old_sum, err, v;
      bit [31:0] elapsed;
      rev = regs[CSR_MODE][32];
      strength = {48'd0, regs[CSR_MODE][31:16]};
      period = {48'd0, regs[CSR_MODE][15:0]};
      if (period == 0) period = 1;
      err = sp - act;
      old_sum = err_sum;
      held_actual = int'(act);
      if (arm_pending) begin
         prev_err = int'(err);
         last_drive = 0;
         last_time = tick_now;
         arm_pending = 1'b0;
         return 1'b0;
      end
      elapsed = tick_now - last_time;
      el = {32'd0, elapsed};
      if (el < period) return 1'b0;
      r = {48'd0, regs[CSR_ISLIM][15:0]};
      spf = sp;
      if (r != 0) spf = clamp(spf, act - r, act + r);
      f = gain_prod(spf, regs[CSR_KF][31:0]);
      p = gain_prod(err, regs[CSR_KP][31:0]);
      d = gain_prod(err - longint'(prev_err), regs[CSR_KD][31:0]) / el;
      err_sum = clamp(err_sum + err * el, -SAT_MAG, SAT_MAG);
      i = gain_prod(err_sum, regs[CSR_KI][31:0]);
      if (rev) begin
         f = -f; p = -p; d = -d; i = -i;
      end
      ilim = longint'({48'd0, regs[CSR_ISLIM][31:16]}) * 65536;
      if (ilim != 0 && !(-ilim < i && i < ilim)) begin
         i = clamp(i, -ilim, ilim);
         err_sum = old_sum;
      end
      outv = f + p + i + d;
      lastq = longint'(last_drive) * 65536;
      rise = {48'd0, regs[CSR_RAMP][31:16]};
      desc = longint'($signed(regs[CSR_RAMP][15:0]));
      if (rise != 0 && desc != 0) begin
         up = rise * el * 256;
         dn = desc * el * 256;
         if (last_drive > 0) begin
            lo = lastq + dn; hi = lastq + up;
         end else begin
            lo = lastq - up; hi = lastq - dn;
         end
         if (!(lo < outv && outv < hi)) begin
            outv = clamp(outv, lo, hi);
            err_sum = old_sum;
         end
      end
      mn = longint'($signed(regs[CSR_OLIM][31:16])) * 65536;
      mx = longint'($signed(regs[CSR_OLIM][15:0])) * 65536;
      if (mn != mx && !(mn < outv && outv < mx)) begin
         outv = clamp(outv, mn, mx);
         err_sum = old_sum;
      end
      outv = clamp(outv, -PRE_MAG, PRE_MAG);
      if (strength != 0)
         outv = longint'(last_drive) * strength + floor_q16(outv * (65536 - strength));
      v = clamp(floor_q16(outv + 32768), -32768, 32767);
      last_drive = int'(v);
      last_time = tick_now;
      prev_err = int'(err);
      return 1'b1;
   endfunction

   function automatic rsp_type predict_item(req_type it);
      rsp_type res;
      bit upd;
      upd = 1'b0;
      case (it.action)
         ACT_TICK: tick_now++;
         ACT_SAMPLE: begin
            held_setpoint = int'(it.setpoint);
            upd = pid_predict(longint'(it.actual), longint'(held_setpoint));
         end
         ACT_REPEAT: upd = pid_predict(longint'(held_actual), longint'(held_setpoint));
         ACT_RESET: begin
            arm_pending = 1'b1;
            err_sum = 0;
         end
         ACT_SKIP: last_time = tick_now;
         default: ;
      endcase
      res.drive = last_drive[15:0];
      res.updated = upd;
      return res;
   endfunction

   task automatic model_reset();
      regs = '{default: '0};
      regs[CSR_MODE] = MODE_RESET;
      tick_now = 0; last_time = 0; prev_err = 0; err_sum = 0;
      last_drive = 0; held_actual = 0; held_setpoint = 0; arm_pending = 1'b1;
   endtask

   task automatic send_item(input logic [ACTION_W-1:0] action, input int act, input int sp);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data.action = action;
      req_data.actual = act[15:0];
      req_data.setpoint = sp[15:0];
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      drive_expect.push_back(predict_item(req_data));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      @(negedge clock);
      while (drive_expect.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_write = 1'b0;
      regs[idx] = (idx == CSR_MODE) ? val : {1'b0, val[31:0]};
   endtask

   always begin
      int n;
      @(negedge clock);
      n = calm ? 0 : $urandom_range(0, 10);
      rsp_ready = 1'b0;
      repeat (n) @(negedge clock);
      rsp_ready = 1'b1;
      do @(posedge clock); while (!rsp_valid);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_expect.size() == 0) begin
            report("result with nothing expected");
         end else begin
            want = drive_expect.pop_front();
            if (rsp_data.drive !== want.drive)
               report($sformatf("drive %0d, expected %0d", rsp_data.drive, want.drive));
            if (rsp_data.updated !== want.updated)
               report($sformatf("updated %0b, expected %0b", rsp_data.updated,
                                want.updated));
         end
      end
   end

   function automatic logic [31:0] rand_gain();
      return $urandom >> $urandom_range(10, 31);
   endfunction

   task automatic random_config(input bit extreme_hi, input bit extreme_lo);
      logic [CSR_W-1:0] mode;
      if (extreme_hi) begin
         for (int k = 0; k < 8; k++) write_reg(k[CSR_IDX_W-1:0], '1);
         write_reg(CSR_MODE, {1'b1, 16'hFFFF, 16'd1});
      end else if (extreme_lo) begin
         for (int k = 0; k < 8; k++) write_reg(k[CSR_IDX_W-1:0], '0);
      end else begin
         write_reg(CSR_KP, {1'b0, rand_gain()});
         write_reg(CSR_KI, {1'b0, rand_gain() >> 4});
         write_reg(CSR_KD, {1'b0, rand_gain()});
         write_reg(CSR_KF, {1'b0, rand_gain()});
         write_reg(CSR_OLIM, {1'b0, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom});
         write_reg(CSR_ISLIM, {1'b0, ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom});
         write_reg(CSR_RAMP, {1'b0, ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom});
         mode[32] = 1'($urandom_range(0, 1));
         mode[31:16] = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
         mode[15:0] = 16'($urandom_range(0, 4));
         write_reg(CSR_MODE, mode);
      end
   endtask

   task automatic random_items(input int count);
      int sel;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(0, 99);
         if (k == count / 2) begin
            // hold off until the pipe is empty
            drain();
         end
         if (sel < 45) send_item(ACT_TICK, $urandom, $urandom);
         else if (sel < 75) send_item(ACT_SAMPLE, $urandom, $urandom);
         else if (sel < 87) send_item(ACT_REPEAT, $urandom, $urandom);
         else if (sel < 92) send_item(ACT_SKIP, $urandom, $urandom);
         else if (sel < 96) send_item(ACT_RESET, $urandom, $urandom);
         else send_item(ACTION_W'($urandom_range(5, ACT_SPARE)), $urandom, $urandom);
      end
   endtask

   task automatic test_arming_and_hold();
      calm = 1;
      send_item(ACT_SAMPLE, 100, -200);
      send_item(ACT_SAMPLE, 32767, -32768);
      repeat (19) send_item(ACT_TICK, 0, 0);
      send_item(ACT_REPEAT, 0, 0);
      send_item(ACT_TICK, 0, 0);
      send_item(ACT_REPEAT, 0, 0);
      drain();
   endtask

   task automatic test_directed_cases();
      calm = 0;
      write_reg(CSR_KP, {1'b0, 32'h0001_0000});
      write_reg(CSR_KI, {1'b0, 32'h0000_0100});
      write_reg(CSR_KD, {1'b0, 32'h0000_8000});
      write_reg(CSR_KF, {1'b0, 32'h0000_4000});
      write_reg(CSR_OLIM, {1'b0, 16'd1000, 16'hFC18});
      write_reg(CSR_ISLIM, {1'b0, 16'd50, 16'd300});
      write_reg(CSR_RAMP, {1'b0, 16'h0200, 16'hFF00});
      write_reg(CSR_MODE, {1'b0, 16'd0, 16'd0});
      send_item(ACT_RESET, 0, 0);
      send_item(ACT_SAMPLE, -32768, 32767);
      send_item(ACT_SAMPLE, 32767, -32768);
      send_item(ACT_TICK, 0, 0);
      send_item(ACT_SAMPLE, -32768, 32767);
      send_item(ACT_TICK, 0, 0);
      send_item(ACT_REPEAT, 0, 0);
      send_item(ACT_SKIP, 0, 0);
      send_item(ACT_SAMPLE, 5, 9);
      send_item(3'd5, -1, -1);
      send_item(3'd6, 0, 0);
      send_item(ACT_SPARE, -1, -1);
      drain();
      write_reg(CSR_MODE, {1'b1, 16'h8000, 16'd2});
      write_reg(CSR_OLIM, {1'b0, 32'h0000_0000});
      write_reg(CSR_ISLIM, {1'b0, 32'h0000_0000});
      write_reg(CSR_RAMP, {1'b0, 32'h0000_0000});
      repeat (3) send_item(ACT_TICK, 0, 0);
      send_item(ACT_SAMPLE, -32768, 32767);
      repeat (2) send_item(ACT_TICK, 0, 0);
      send_item(ACT_SAMPLE, 32767, -32768);
      drain();
   endtask

   task automatic test_random_settings();
      for (int ph = 0; ph < 7; ph++) begin
         calm = (ph == 2);
         random_config(ph == 5, ph == 6);
         random_items(115);
         drain();
      end
   endtask

   initial begin
      calm = 1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      model_reset();
      repeat (8) @(negedge clock);
      reset = 1'b0;
      test_arming_and_hold();
      test_directed_cases();
      test_random_settings();
      if (fail_count == 0) begin
         $display("pid_controller_with_ramp_limits_test: PASS");
      end else begin
         $display("pid_controller_with_ramp_limits_test: FAIL");
      end
      $finish;
   end

endmodule
